// ===== hw/rtl/tspr_pkg.sv =====
// shared types, constants and helpers of the transport stream pes reassembler
package tspr_pkg;

   localparam int PACKET_BYTES  = 188;
   localparam int COUNT_BITS    = 20;
   localparam int POS_BITS      = $clog2(PACKET_BYTES + 1);
   localparam int PID_BITS      = 13;
   localparam int SKIP_BITS     = 9;
   localparam int LEN_BITS      = 16;
   localparam int CC_BITS       = 4;
   localparam int HDR_BITS      = 24;
   localparam int CMP_BITS      = COUNT_BITS + 1;
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   localparam logic [PID_BITS-1:0]  PID_RESET      = '1;
   localparam logic [SKIP_BITS-1:0] SKIP_SHORT     = 9'd6;
   localparam logic [SKIP_BITS-1:0] SKIP_EXTENDED  = 9'd9;
   localparam logic [CMP_BITS-1:0]  PES_HDR_FIXED  = CMP_BITS'(6);

   // stream ids without the optional pes header extension
   localparam logic [7:0] SID_PROGRAM_MAP   = 8'hBC;
   localparam logic [7:0] SID_PADDING       = 8'hBE;
   localparam logic [7:0] SID_PRIVATE_2     = 8'hBF;
   localparam logic [7:0] SID_ECM           = 8'hF0;
   localparam logic [7:0] SID_EMM           = 8'hF1;
   localparam logic [7:0] SID_DIRECTORY     = 8'hFF;
   localparam logic [7:0] SID_DSMCC         = 8'hF2;
   localparam logic [7:0] SID_TYPE_E        = 8'hF8;

   typedef enum logic [2:0] {
      STATUS_UNEXPECTED_PID = 3'd0,
      STATUS_LOST           = 3'd1,
      STATUS_STARTED        = 3'd2,
      STATUS_CONTINUE       = 3'd3,
      STATUS_FINISHED       = 3'd4
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type   result_kind;
      logic [7:0] payload_byte;
      status_type packet_status;
      logic       last_of_run;
   } result_type;

   // results made by one byte, handed to the result queue
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } parse_out_type;

   function automatic logic has_extension(input logic [7:0] id);
      logic ext;
      case (id) inside
         SID_PROGRAM_MAP, SID_PADDING, SID_PRIVATE_2, SID_ECM,
         SID_EMM, SID_DIRECTORY, SID_DSMCC, SID_TYPE_E: ext = 1'b0;
         default: ext = 1'b1;
      endcase
      return ext;
   endfunction

endpackage

// ===== hw/rtl/tspr_req_if.sv =====
// request channel: transport stream bytes
interface tspr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       first_of_packet;

   modport source (output valid, output stream_byte, output first_of_packet, input ready);
   modport sink (input valid, input stream_byte, input first_of_packet, output ready);
endinterface

// ===== hw/rtl/tspr_rsp_if.sv =====
// result channel: payload bytes and packet status
interface tspr_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] payload_byte;
   logic [2:0] packet_status;
   logic       last_of_run;

   modport source (output valid, output result_kind, output payload_byte,
                   output packet_status, output last_of_run, input ready);
   modport sink (input valid, input result_kind, input payload_byte,
                 input packet_status, input last_of_run, output ready);
endinterface

// ===== hw/rtl/tspr_parser.sv =====
// input register, header parse and pes assembly state
module tspr_parser (
   input  logic                            clock,
   input  logic                            reset,
   tspr_req_if.sink                        req_chan,
   input  logic                            csr_write_enable,
   input  logic [tspr_pkg::PID_BITS-1:0]   csr_write_data,
   input  logic                            room,
   output tspr_pkg::parse_out_type         parse_out
);

   logic                             in_valid_ff, in_valid_in;
   logic [7:0]                       in_byte_ff;
   logic                             in_first_ff;

   logic [tspr_pkg::PID_BITS-1:0]    wanted_ff, wanted_in;
   logic [tspr_pkg::POS_BITS-1:0]    pos_ff, pos_in;
   logic [tspr_pkg::HDR_BITS-1:0]    hdr_ff, hdr_in;
   logic [7:0]                       alen_ff, alen_in;
   logic                             accepted_ff, accepted_in;
   logic                             started_ff, started_in;
   logic                             known_ff, known_in;
   logic [tspr_pkg::CC_BITS-1:0]     prev_ff, prev_in;
   logic [tspr_pkg::SKIP_BITS-1:0]   skip_ff, skip_in;
   logic [tspr_pkg::LEN_BITS-1:0]    len_ff, len_in;
   logic [7:0]                       sid_ff, sid_in;
   logic [tspr_pkg::COUNT_BITS-1:0]  cnt_ff, cnt_in;
   tspr_pkg::status_type             pending_ff, pending_in;

   logic                             fire;
   logic                             live;
   logic [tspr_pkg::POS_BITS-1:0]    idx;
   logic [tspr_pkg::HDR_BITS-1:0]    hdr_shift;
   logic                             eff_started;
   logic                             eff_known;
   logic [tspr_pkg::CC_BITS-1:0]     eff_prev;
   logic                             payload;
   logic                             emit;
   logic [tspr_pkg::POS_BITS-1:0]    p;
   logic                             done;
   tspr_pkg::result_type             status_res;

   assign fire             = in_valid_ff && room;
   assign req_chan.ready   = !in_valid_ff || room;
   assign in_valid_in      = (req_chan.valid && req_chan.ready) ? 1'b1 :
                             (fire ? 1'b0 : in_valid_ff);

   always_comb begin
      idx         = in_first_ff ? '0 : pos_ff;
      live        = fire && (idx < tspr_pkg::POS_BITS'(tspr_pkg::PACKET_BYTES));
      hdr_shift   = {hdr_ff[15:0], in_byte_ff};
      eff_started = started_ff && !hdr_shift[22];
      eff_known   = known_ff && !hdr_shift[22];
      eff_prev    = hdr_shift[22] ? '0 : prev_ff;

      wanted_in   = wanted_ff;
      pos_in      = pos_ff;
      hdr_in      = hdr_ff;
      alen_in     = alen_ff;
      accepted_in = accepted_ff;
      started_in  = started_ff;
      known_in    = known_ff;
      prev_in     = prev_ff;
      skip_in     = skip_ff;
      len_in      = len_ff;
      sid_in      = sid_ff;
      cnt_in      = cnt_ff;
      pending_in  = pending_ff;

      payload     = 1'b0;
      emit        = 1'b0;
      p           = '0;
      done        = 1'b0;
      status_res  = '0;
      parse_out   = '0;

      if (live) begin
         pos_in = idx + tspr_pkg::POS_BITS'(1);
         if (idx >= tspr_pkg::POS_BITS'(1) && idx <= tspr_pkg::POS_BITS'(3)) begin
            hdr_in = hdr_shift;
            // last header byte: pid, start flag and continuity check
            if (idx == tspr_pkg::POS_BITS'(3)) begin
               accepted_in = 1'b0;
               if (hdr_shift[20:8] != wanted_ff) begin
                  pending_in = tspr_pkg::STATUS_UNEXPECTED_PID;
               end else begin
                  if (hdr_shift[22]) begin
                     started_in = 1'b0;
                     known_in   = 1'b0;
                     prev_in    = '0;
                     skip_in    = '0;
                     len_in     = '0;
                     sid_in     = '0;
                     cnt_in     = '0;
                  end
                  if (eff_started && eff_known &&
                      hdr_shift[3:0] != eff_prev + tspr_pkg::CC_BITS'(1)) begin
                     pending_in = tspr_pkg::STATUS_LOST;
                  end else begin
                     prev_in     = hdr_shift[3:0];
                     known_in    = 1'b1;
                     accepted_in = 1'b1;
                     if (!eff_started) begin
                        started_in = 1'b1;
                        skip_in    = tspr_pkg::SKIP_SHORT;
                        len_in     = '0;
                        sid_in     = '0;
                        cnt_in     = '0;
                        pending_in = tspr_pkg::STATUS_STARTED;
                     end else begin
                        pending_in = tspr_pkg::STATUS_CONTINUE;
                     end
                  end
               end
            end
         end else if (idx >= tspr_pkg::POS_BITS'(4) && accepted_ff) begin
            // adaptation field present when control bit 1 is set
            if (hdr_ff[5]) begin
               if (idx == tspr_pkg::POS_BITS'(4)) begin
                  alen_in = in_byte_ff;
               end else if (9'(idx) >= 9'(alen_ff) + 9'd5) begin
                  payload = 1'b1;
                  p       = tspr_pkg::POS_BITS'(9'(idx) - 9'(alen_ff) - 9'd5);
               end
            end else begin
               payload = 1'b1;
               p       = idx - tspr_pkg::POS_BITS'(4);
            end
            if (payload) begin
               emit = 1'b1;
               if (pending_ff == tspr_pkg::STATUS_STARTED) begin
                  if (p == tspr_pkg::POS_BITS'(3)) begin
                     sid_in = in_byte_ff;
                     if (tspr_pkg::has_extension(in_byte_ff)) begin
                        skip_in = tspr_pkg::SKIP_EXTENDED;
                     end
                  end else if (p == tspr_pkg::POS_BITS'(4) || p == tspr_pkg::POS_BITS'(5)) begin
                     len_in = {len_ff[7:0], in_byte_ff};
                  end else if (p == tspr_pkg::POS_BITS'(8) &&
                               tspr_pkg::has_extension(sid_ff)) begin
                     skip_in = tspr_pkg::SKIP_EXTENDED + tspr_pkg::SKIP_BITS'(in_byte_ff);
                  end
                  emit = tspr_pkg::SKIP_BITS'(p) >= skip_in;
               end
               if (emit) begin
                  parse_out.count              = 2'd1;
                  parse_out.first.result_kind  = tspr_pkg::KIND_PAYLOAD;
                  parse_out.first.payload_byte = in_byte_ff;
                  parse_out.first.packet_status = tspr_pkg::STATUS_UNEXPECTED_PID;
                  parse_out.first.last_of_run  = 1'b1;
                  if (cnt_ff != '1) begin
                     cnt_in = cnt_ff + tspr_pkg::COUNT_BITS'(1);
                  end
               end
            end
         end

         // last byte of the packet: report how it was handled
         if (idx == tspr_pkg::POS_BITS'(tspr_pkg::PACKET_BYTES - 1)) begin
            if (accepted_ff && pending_ff != tspr_pkg::STATUS_STARTED) begin
               done = (len_in != '0) &&
                      (tspr_pkg::CMP_BITS'(cnt_in) + tspr_pkg::CMP_BITS'(skip_in) >=
                       tspr_pkg::CMP_BITS'(len_in) + tspr_pkg::PES_HDR_FIXED);
               pending_in = done ? tspr_pkg::STATUS_FINISHED : tspr_pkg::STATUS_CONTINUE;
            end
            status_res.result_kind   = tspr_pkg::KIND_STATUS;
            status_res.payload_byte  = '0;
            status_res.packet_status = pending_in;
            status_res.last_of_run   = 1'b1;
            if (emit) begin
               parse_out.count             = 2'd2;
               parse_out.first.last_of_run = 1'b0;
               parse_out.second            = status_res;
            end else begin
               parse_out.count = 2'd1;
               parse_out.first = status_res;
            end
         end
      end

      if (csr_write_enable) begin
         wanted_in   = csr_write_data;
         started_in  = 1'b0;
         known_in    = 1'b0;
         prev_in     = '0;
         skip_in     = '0;
         len_in      = '0;
         sid_in      = '0;
         cnt_in      = '0;
         accepted_in = 1'b0;
         pending_in  = tspr_pkg::STATUS_UNEXPECTED_PID;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff  <= req_chan.stream_byte;
         in_first_ff <= req_chan.first_of_packet;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         wanted_ff   <= tspr_pkg::PID_RESET;
         pos_ff      <= '0;
         hdr_ff      <= '0;
         alen_ff     <= '0;
         accepted_ff <= 1'b0;
         started_ff  <= 1'b0;
         known_ff    <= 1'b0;
         prev_ff     <= '0;
         skip_ff     <= '0;
         len_ff      <= '0;
         sid_ff      <= '0;
         cnt_ff      <= '0;
         pending_ff  <= tspr_pkg::STATUS_UNEXPECTED_PID;
      end else begin
         in_valid_ff <= in_valid_in;
         wanted_ff   <= wanted_in;
         pos_ff      <= pos_in;
         hdr_ff      <= hdr_in;
         alen_ff     <= alen_in;
         accepted_ff <= accepted_in;
         started_ff  <= started_in;
         known_ff    <= known_in;
         prev_ff     <= prev_in;
         skip_ff     <= skip_in;
         len_ff      <= len_in;
         sid_ff      <= sid_in;
         cnt_ff      <= cnt_in;
         pending_ff  <= pending_in;
      end
   end

   a_started_pending: assert property (@(posedge clock) disable iff (reset)
      (pending_ff == tspr_pkg::STATUS_STARTED) |-> started_ff)
      else $error("started status without an open assembly");

   a_started_known: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> known_ff)
      else $error("open assembly without a continuity counter");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (parse_out.count == 2'd2) |->
         (parse_out.second.result_kind == tspr_pkg::KIND_STATUS &&
          parse_out.second.last_of_run && !parse_out.first.last_of_run))
      else $error("two results without a closing status");

endmodule

// ===== hw/rtl/tspr_result_fifo.sv =====
// result queue: takes up to two results a cycle, hands out one
module tspr_result_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  tspr_pkg::parse_out_type parse_out,
   input  logic                    pop,
   output logic                    room,
   output logic                    not_empty,
   output tspr_pkg::result_type    head
);

   tspr_pkg::result_type                 entries_ff [tspr_pkg::FIFO_DEPTH];
   logic [tspr_pkg::FIFO_PTR_BITS-1:0]   wr_ff, wr_in;
   logic [tspr_pkg::FIFO_PTR_BITS-1:0]   rd_ff, rd_in;
   logic [tspr_pkg::FIFO_CNT_BITS-1:0]   count_ff, count_in;
   logic [tspr_pkg::FIFO_PTR_BITS-1:0]   wr_next;

   assign room      = count_ff <= tspr_pkg::FIFO_CNT_BITS'(tspr_pkg::FIFO_DEPTH - 2);
   assign not_empty = count_ff != '0;
   assign head      = entries_ff[rd_ff];
   assign wr_next   = wr_ff + tspr_pkg::FIFO_PTR_BITS'(1);

   always_comb begin
      wr_in    = wr_ff + tspr_pkg::FIFO_PTR_BITS'(parse_out.count);
      rd_in    = pop ? rd_ff + tspr_pkg::FIFO_PTR_BITS'(1) : rd_ff;
      count_in = count_ff + tspr_pkg::FIFO_CNT_BITS'(parse_out.count) -
                 tspr_pkg::FIFO_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (parse_out.count != 2'd0) begin
         entries_ff[wr_ff] <= parse_out.first;
      end
      if (parse_out.count == 2'd2) begin
         entries_ff[wr_next] <= parse_out.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tspr_pkg::FIFO_CNT_BITS'(tspr_pkg::FIFO_DEPTH))
      else $error("result queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (parse_out.count != 2'd0) |->
         ((tspr_pkg::FIFO_CNT_BITS + 1)'(count_ff) + (tspr_pkg::FIFO_CNT_BITS + 1)'(parse_out.count)
          <= (tspr_pkg::FIFO_CNT_BITS + 1)'(tspr_pkg::FIFO_DEPTH)))
      else $error("results pushed into a full queue");

endmodule

// ===== hw/rtl/ts_pes_reassembler.sv =====
// top level of the transport stream pes reassembler
//
//  channel   dir  handshake          payload
//  req_chan  in   valid / ready      stream_byte, first_of_packet
//  rsp_chan  out  valid / ready      result_kind, payload_byte, packet_status, last_of_run
//  csr       in   csr_write_enable   csr_write_data (wanted pid, 13 bits)
//
// one request per cycle unless ready drops; results pass the input register and the queue
// a packet's last byte can make two results but its four header bytes make none, so the
// 4-entry result queue absorbs the burst; req_chan.ready drops while the queue holds more
// than two results and a request waits in the input register
// reset is synchronous and active high and restores pid 8191 with an empty assembler
// a stalled rsp_chan holds requests in the input register; nothing is dropped
module ts_pes_reassembler (
   input  logic                          clock,
   input  logic                          reset,
   tspr_req_if.sink                      req_chan,
   tspr_rsp_if.source                    rsp_chan,
   input  logic                          csr_write_enable,
   input  logic [tspr_pkg::PID_BITS-1:0] csr_write_data
);

   // results of one byte, from the parser into the queue
   tspr_pkg::parse_out_type parse_out;
   tspr_pkg::result_type    head;
   logic                    room;
   logic                    not_empty;
   logic                    pop;

   // header parse, continuity check and pes header skip
   tspr_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .room             (room),
      .parse_out        (parse_out)
   );

   // result queue: one result per handshake
   tspr_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .parse_out (parse_out),
      .pop       (pop),
      .room      (room),
      .not_empty (not_empty),
      .head      (head)
   );

   assign pop                    = not_empty && rsp_chan.ready;
   assign rsp_chan.valid         = not_empty;
   assign rsp_chan.result_kind   = head.result_kind;
   assign rsp_chan.payload_byte  = head.payload_byte;
   assign rsp_chan.packet_status = head.packet_status;
   assign rsp_chan.last_of_run   = head.last_of_run;

endmodule
